// ----- src/qalu_pkg.sv -----
// Shared types, constants and rounding and saturation helpers for the quaternion ALU.
package qalu_pkg;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_SCALE = 3'd1,
    OP_DOT   = 3'd2,
    OP_NORM  = 3'd3,
    OP_ROT   = 3'd4,
    OP_UNROT = 3'd5
  } op_t;

  localparam int S_W    = 49;
  localparam int INV_W  = 25;
  localparam int DIV_N  = 49;
  localparam int SQRT_N = 25;
  localparam int LAT    = 88;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic            vld;
    op_t             op;
    logic            sat;
    logic            ident;
    logic [S_W-1:0]  s;
    logic [3:0][31:0] w;
    logic [2:0][31:0] v;
    logic [2:0][31:0] c;
  } front_t;

  typedef struct packed {
    logic            vld;
    op_t             op;
    logic            sat;
    logic            ident;
    logic [S_W-1:0]  s;
    logic [3:0][31:0] w;
  } mid_t;

  typedef struct packed {
    logic             vld;
    op_t              op;
    logic             sat;
    logic             ident;
    logic [INV_W-1:0] inv;
    logic [3:0][31:0] w;
  } nrm_t;

  typedef struct packed {
    logic             vld;
    logic             sat;
    logic [3:0][31:0] w;
  } res_t;

  function automatic logic signed [49:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd32768;
    return $signed(t[65:16]);
  endfunction

  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- src/qalu_front.sv -----
// Front pipeline: sixteen products, exact sums, rounding and per-operation selection.
module qalu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  qalu_pkg::op_t          in_op,
  input  logic [3:0][31:0]       in_a,
  input  logic [3:0][31:0]       in_b,
  input  logic [30:0]            eps_sq,
  output qalu_pkg::front_t       fo
);

  logic [3:0][3:0][31:0] opa;
  logic [3:0][3:0][31:0] opb;
  logic [3:0][3:0]       neg;

  logic signed [63:0]    p_r [4][4];
  logic [3:0][3:0]       neg_r;
  logic signed [64:0]    pe [4][4];
  logic signed [64:0]    h_r [4][2];
  logic signed [65:0]    sum_r [4];
  logic signed [49:0]    rn_r [4];

  logic [3:0]            vld_r;
  qalu_pkg::op_t         op_r [4];
  logic [3:0][31:0]      a_r [4];
  logic [3:0][31:0]      b_r [4];

  logic [32:0]           sr [4];
  logic [32:0]           c2 [4];
  qalu_pkg::front_t      fo_nxt;
  qalu_pkg::front_t      fo_r;

  always_comb begin
    opa = '0;
    opb = '0;
    neg = '0;
    case (in_op)
      qalu_pkg::OP_MUL: begin
        opa[0][0] = in_a[3]; opb[0][0] = in_b[0];
        opa[0][1] = in_a[0]; opb[0][1] = in_b[3];
        opa[0][2] = in_a[1]; opb[0][2] = in_b[2];
        opa[0][3] = in_a[2]; opb[0][3] = in_b[1]; neg[0][3] = 1'b1;
        opa[1][0] = in_a[3]; opb[1][0] = in_b[1];
        opa[1][1] = in_a[0]; opb[1][1] = in_b[2]; neg[1][1] = 1'b1;
        opa[1][2] = in_a[1]; opb[1][2] = in_b[3];
        opa[1][3] = in_a[2]; opb[1][3] = in_b[0];
        opa[2][0] = in_a[3]; opb[2][0] = in_b[2];
        opa[2][1] = in_a[0]; opb[2][1] = in_b[1];
        opa[2][2] = in_a[1]; opb[2][2] = in_b[0]; neg[2][2] = 1'b1;
        opa[2][3] = in_a[2]; opb[2][3] = in_b[3];
        opa[3][0] = in_a[3]; opb[3][0] = in_b[3];
        opa[3][1] = in_a[0]; opb[3][1] = in_b[0]; neg[3][1] = 1'b1;
        opa[3][2] = in_a[1]; opb[3][2] = in_b[1]; neg[3][2] = 1'b1;
        opa[3][3] = in_a[2]; opb[3][3] = in_b[2]; neg[3][3] = 1'b1;
      end
      qalu_pkg::OP_SCALE: begin
        for (int k = 0; k < 4; k++) begin
          opa[k][0] = in_a[k];
          opb[k][0] = in_b[0];
        end
      end
      qalu_pkg::OP_DOT: begin
        for (int j = 0; j < 4; j++) begin
          opa[0][j] = in_a[j];
          opb[0][j] = in_b[j];
        end
      end
      qalu_pkg::OP_NORM: begin
        for (int j = 0; j < 4; j++) begin
          opa[0][j] = in_a[j];
          opb[0][j] = in_a[j];
        end
      end
      qalu_pkg::OP_ROT, qalu_pkg::OP_UNROT: begin
        opa[0][0] = in_a[1]; opb[0][0] = in_b[2];
        opa[0][1] = in_a[2]; opb[0][1] = in_b[1];
        opa[1][0] = in_a[2]; opb[1][0] = in_b[0];
        opa[1][1] = in_a[0]; opb[1][1] = in_b[2];
        opa[2][0] = in_a[0]; opb[2][0] = in_b[1];
        opa[2][1] = in_a[1]; opb[2][1] = in_b[0];
        for (int k = 0; k < 3; k++) begin
          neg[k][0] = (in_op == qalu_pkg::OP_UNROT);
          neg[k][1] = (in_op == qalu_pkg::OP_ROT);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        p_r[k][j] <= $signed(opa[k][j]) * $signed(opb[k][j]);
      end
    end
    neg_r <= neg;
    for (int k = 0; k < 4; k++) begin
      h_r[k][0] <= pe[k][0] + pe[k][1];
      h_r[k][1] <= pe[k][2] + pe[k][3];
      sum_r[k]  <= 66'(h_r[k][0]) + 66'(h_r[k][1]);
      rn_r[k]   <= qalu_pkg::rnd16(sum_r[k]);
    end
    vld_r <= {vld_r[2:0], in_vld};
    op_r[0] <= in_op;
    a_r[0]  <= in_a;
    b_r[0]  <= in_b;
    for (int i = 1; i < 4; i++) begin
      op_r[i] <= op_r[i-1];
      a_r[i]  <= a_r[i-1];
      b_r[i]  <= b_r[i-1];
    end
    fo_r <= fo_nxt;
    if (!rst_n) begin
      vld_r    <= '0;
      fo_r.vld <= 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        pe[k][j] = neg_r[k][j] ? -65'(p_r[k][j]) : 65'(p_r[k][j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sr[k] = qalu_pkg::sat32(67'(rn_r[k]));
      c2[k] = qalu_pkg::sat32($signed({{16{rn_r[k][49]}}, rn_r[k], 1'b0}));
    end
    fo_nxt     = '0;
    fo_nxt.vld = vld_r[3];
    fo_nxt.op  = op_r[3];
    case (op_r[3])
      qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE: begin
        for (int k = 0; k < 4; k++) begin
          fo_nxt.w[k] = sr[k][31:0];
        end
        fo_nxt.sat = sr[0][32] | sr[1][32] | sr[2][32] | sr[3][32];
      end
      qalu_pkg::OP_DOT: begin
        fo_nxt.w[0] = sr[0][31:0];
        fo_nxt.sat  = sr[0][32];
      end
      qalu_pkg::OP_NORM: begin
        fo_nxt.s     = rn_r[0][qalu_pkg::S_W-1:0];
        fo_nxt.ident = (rn_r[0][qalu_pkg::S_W-1:0] <= {18'b0, eps_sq});
        fo_nxt.w     = a_r[3];
      end
      qalu_pkg::OP_ROT, qalu_pkg::OP_UNROT: begin
        for (int k = 0; k < 3; k++) begin
          fo_nxt.c[k] = c2[k][31:0];
          fo_nxt.v[k] = b_r[3][k];
        end
        fo_nxt.sat = c2[0][32] | c2[1][32] | c2[2][32];
        fo_nxt.w   = a_r[3];
      end
      default: ;
    endcase
  end

  assign fo = fo_r;

endmodule

// ----- src/qalu_rot.sv -----
// Rotation back end: second cross product, scaled term and final sums.
module qalu_rot (
  input  logic             clk,
  input  logic             rst_n,
  input  qalu_pkg::front_t fi,
  output qalu_pkg::mid_t   mo
);

  qalu_pkg::front_t   it_r [3];
  logic signed [63:0] tp_r [3];
  logic signed [63:0] xp_r [3][2];
  logic signed [49:0] tr_r [3];
  logic signed [65:0] x_r [3];
  logic [32:0]        t_r [3];
  logic signed [49:0] xr_r [3];

  logic signed [65:0] te [3];
  logic signed [65:0] xd [3];
  logic [32:0]        rs [3];
  qalu_pkg::mid_t     mo_nxt;
  qalu_pkg::mid_t     mo_r;

  logic               rot1;
  logic               rot2;

  assign rot1 = (it_r[0].op == qalu_pkg::OP_ROT);
  assign rot2 = (it_r[2].op == qalu_pkg::OP_ROT) || (it_r[2].op == qalu_pkg::OP_UNROT);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      te[i] = rot1 ? -66'(tp_r[i]) : 66'(tp_r[i]);
      xd[i] = rot1 ? (66'(xp_r[i][0]) - 66'(xp_r[i][1]))
                   : (66'(xp_r[i][1]) - 66'(xp_r[i][0]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tp_r[i] <= $signed(fi.w[3]) * $signed(fi.c[i]);
    end
    xp_r[0][0] <= $signed(fi.w[1]) * $signed(fi.c[2]);
    xp_r[0][1] <= $signed(fi.w[2]) * $signed(fi.c[1]);
    xp_r[1][0] <= $signed(fi.w[2]) * $signed(fi.c[0]);
    xp_r[1][1] <= $signed(fi.w[0]) * $signed(fi.c[2]);
    xp_r[2][0] <= $signed(fi.w[0]) * $signed(fi.c[1]);
    xp_r[2][1] <= $signed(fi.w[1]) * $signed(fi.c[0]);
    for (int i = 0; i < 3; i++) begin
      tr_r[i] <= qalu_pkg::rnd16(te[i]);
      x_r[i]  <= xd[i];
      t_r[i]  <= qalu_pkg::sat32(67'($signed(it_r[1].v[i])) + 67'(tr_r[i]));
      xr_r[i] <= qalu_pkg::rnd16(x_r[i]);
    end
    it_r[0] <= fi;
    it_r[1] <= it_r[0];
    it_r[2] <= it_r[1];
    mo_r    <= mo_nxt;
    if (!rst_n) begin
      it_r[0].vld <= 1'b0;
      it_r[1].vld <= 1'b0;
      it_r[2].vld <= 1'b0;
      mo_r.vld    <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = qalu_pkg::sat32(67'($signed(t_r[i][31:0])) + 67'(xr_r[i]));
    end
    mo_nxt.vld   = it_r[2].vld;
    mo_nxt.op    = it_r[2].op;
    mo_nxt.ident = it_r[2].ident;
    mo_nxt.s     = it_r[2].s;
    mo_nxt.sat   = it_r[2].sat;
    mo_nxt.w     = it_r[2].w;
    if (rot2) begin
      mo_nxt.w   = {32'h0, rs[2][31:0], rs[1][31:0], rs[0][31:0]};
      mo_nxt.sat = it_r[2].sat | t_r[0][32] | t_r[1][32] | t_r[2][32]
                 | rs[0][32] | rs[1][32] | rs[2][32];
    end
  end

  assign mo = mo_r;

endmodule

// ----- src/qalu_rsqrt.sv -----
// Inverse square root pipeline: restoring divide of 2^48, then digit-by-digit square root.
module qalu_rsqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  qalu_pkg::mid_t mi,
  output qalu_pkg::nrm_t no
);

  localparam int SW = qalu_pkg::S_W;
  localparam int DN = qalu_pkg::DIV_N;
  localparam int QN = qalu_pkg::SQRT_N;

  qalu_pkg::mid_t dit_r [DN+1];
  logic [SW-1:0]  rem_r [DN+1];
  logic [SW-1:0]  q_r [DN+1];

  qalu_pkg::mid_t qit_r [QN+1];
  logic [SW-1:0]  sn_r [QN+1];
  logic [SW:0]    sq_r [QN+1];

  always_ff @(posedge clk) begin
    dit_r[0] <= mi;
    rem_r[0] <= '0;
    q_r[0]   <= '0;
    qit_r[0] <= dit_r[DN];
    sn_r[0]  <= q_r[DN];
    sq_r[0]  <= '0;
    if (!rst_n) begin
      dit_r[0].vld <= 1'b0;
      qit_r[0].vld <= 1'b0;
    end
  end

  for (genvar k = 0; k < DN; k++) begin : g_div
    localparam logic NB = (k == 0);
    logic [SW:0] trial;
    logic        ge;

    assign trial = {rem_r[k], NB};
    assign ge    = (trial >= {1'b0, dit_r[k].s});

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? SW'(trial - {1'b0, dit_r[k].s}) : trial[SW-1:0];
      q_r[k+1]   <= {q_r[k][SW-2:0], ge};
      dit_r[k+1] <= dit_r[k];
      if (!rst_n) begin
        dit_r[k+1].vld <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < QN; k++) begin : g_sqrt
    localparam logic [SW:0] BIT = (SW+1)'(1) << (2 * (QN - 1 - k));
    logic [SW:0] trial;
    logic        ge;

    assign trial = sq_r[k] + BIT;
    assign ge    = ({1'b0, sn_r[k]} >= trial);

    always_ff @(posedge clk) begin
      sn_r[k+1]  <= ge ? (sn_r[k] - trial[SW-1:0]) : sn_r[k];
      sq_r[k+1]  <= ge ? ((sq_r[k] >> 1) + BIT) : (sq_r[k] >> 1);
      qit_r[k+1] <= qit_r[k];
      if (!rst_n) begin
        qit_r[k+1].vld <= 1'b0;
      end
    end
  end

  always_comb begin
    no.vld   = qit_r[QN].vld;
    no.op    = qit_r[QN].op;
    no.sat   = qit_r[QN].sat;
    no.ident = qit_r[QN].ident;
    no.inv   = sq_r[QN][qalu_pkg::INV_W-1:0];
    no.w     = qit_r[QN].w;
  end

endmodule

// ----- src/qalu_norm.sv -----
// Normalize back end: scale by the inverse square root, round, clamp and pick the result.
module qalu_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  qalu_pkg::nrm_t ni,
  output qalu_pkg::res_t ro
);

  qalu_pkg::nrm_t     it_r [2];
  logic signed [63:0] np_r [4];
  logic signed [49:0] nr_r [4];
  logic [32:0]        ns [4];
  qalu_pkg::res_t     ro_nxt;
  qalu_pkg::res_t     ro_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      np_r[i] <= $signed(ni.w[i]) * $signed({1'b0, ni.inv});
      nr_r[i] <= qalu_pkg::rnd16(66'(np_r[i]));
    end
    it_r[0] <= ni;
    it_r[1] <= it_r[0];
    ro_r    <= ro_nxt;
    if (!rst_n) begin
      it_r[0].vld <= 1'b0;
      it_r[1].vld <= 1'b0;
      ro_r.vld    <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ns[i] = qalu_pkg::sat32(67'(nr_r[i]));
    end
    ro_nxt.vld = it_r[1].vld;
    ro_nxt.sat = it_r[1].sat;
    ro_nxt.w   = it_r[1].w;
    if (it_r[1].op == qalu_pkg::OP_NORM) begin
      if (it_r[1].ident) begin
        ro_nxt.w   = {qalu_pkg::Q_ONE, 32'h0, 32'h0, 32'h0};
        ro_nxt.sat = 1'b0;
      end else begin
        ro_nxt.w   = {ns[3][31:0], ns[2][31:0], ns[1][31:0], ns[0][31:0]};
        ro_nxt.sat = ns[0][32] | ns[1][32] | ns[2][32] | ns[3][32];
      end
    end
  end

  assign ro = ro_r;

endmodule

// ----- src/quaternion_alu_core.sv -----
// Top level of the Q16.16 quaternion ALU: register port, pipeline chain and checks.
// One request per clock: busy is never raised, so a request is taken on every
// cycle that start is high. Every request yields exactly one result beat on
// out_valid, in request order; the result is shown for that one cycle only and
// must be captured then. The latency is the same for every operation and is set
// by the normalize path: a 49-stage restoring divider (one quotient bit per
// stage) followed by a 25-stage square-root pipeline (one root bit per stage),
// each behind an input register, with five front stages, four rotation stages
// and three scaling stages around them. eps_sq is read when a request leaves
// the front stages; write it only while no request is in flight.
// cfg_ready is always high.
module quaternion_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_b_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_eps_sq,
  output logic               out_valid,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_r_w,
  output logic               out_saturated
);

  logic [30:0]      eps_sq_r;
  logic             acc;
  qalu_pkg::front_t fr;
  qalu_pkg::mid_t   md;
  qalu_pkg::nrm_t   nr;
  qalu_pkg::res_t   rs;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_sq_r <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      eps_sq_r <= cfg_eps_sq;
    end
  end

  qalu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (acc),
    .in_op  (qalu_pkg::op_t'(in_req_type)),
    .in_a   ({in_a_w, in_a_z, in_a_y, in_a_x}),
    .in_b   ({in_b_w, in_b_z, in_b_y, in_b_x}),
    .eps_sq (eps_sq_r),
    .fo     (fr)
  );

  qalu_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .fi    (fr),
    .mo    (md)
  );

  qalu_rsqrt u_rsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .mi    (md),
    .no    (nr)
  );

  qalu_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .ni    (nr),
    .ro    (rs)
  );

  assign out_valid     = rs.vld;
  assign out_saturated = rs.sat;
  assign out_r_x       = $signed(rs.w[0]);
  assign out_r_y       = $signed(rs.w[1]);
  assign out_r_z       = $signed(rs.w[2]);
  assign out_r_w       = $signed(rs.w[3]);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##(qalu_pkg::LAT) out_valid)
    else $error("request did not produce a result beat at the fixed latency");

  a_dot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fr.vld && fr.op == qalu_pkg::OP_DOT) |->
      (fr.w[1] == 32'h0 && fr.w[2] == 32'h0 && fr.w[3] == 32'h0))
    else $error("dot result carries nonzero upper components");

  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nr.vld && nr.op == qalu_pkg::OP_NORM && !nr.ident) |->
      (nr.inv != '0 && nr.inv <= 25'd16777216))
    else $error("inverse square root out of range");

endmodule

// ----- bench/quat_result_checker.sv -----
// Watches the quaternion ALU ports, computes each expected result and compares it.
`timescale 1ns / 100ps
module quat_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_b_w,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [30:0]        cfg_eps_sq,
  input  logic               out_valid,
  input  logic signed [31:0] out_r_x,
  input  logic signed [31:0] out_r_y,
  input  logic signed [31:0] out_r_z,
  input  logic signed [31:0] out_r_w,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 in_flight
);

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        sat;
  } quat_res_t;

  quat_res_t   awaited_results[$];
  logic [30:0] eps_copy;

  function automatic wide_t round_q16(wide_t v);
    return (v + 80'sd32768) >>> 16;
  endfunction

  function automatic wide_t clamp32(wide_t v, inout logic f);
    if (v > 80'sd2147483647) begin
      f = 1'b1;
      return 80'sd2147483647;
    end
    if (v < -80'sd2147483648) begin
      f = 1'b1;
      return -80'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic quat_res_t quat_expected_result(
    logic [2:0] op, wide_t ax, wide_t ay, wide_t az, wide_t aw,
    wide_t bx, wide_t by, wide_t bz, wide_t bw, logic [30:0] eps);
    wide_t           r[4];
    wide_t           u[3];
    wide_t           v[3];
    wide_t           c[3];
    wide_t           t[3];
    wide_t           s;
    wide_t           sg;
    wide_t           inv;
    longint unsigned quo;
    logic            f;
    quat_res_t       res;
    f = 1'b0;
    for (int i = 0; i < 4; i++) r[i] = 0;
    case (op)
      qalu_pkg::OP_MUL: begin
        r[0] = clamp32(round_q16(aw * bx + ax * bw + ay * bz - az * by), f);
        r[1] = clamp32(round_q16(aw * by - ax * bz + ay * bw + az * bx), f);
        r[2] = clamp32(round_q16(aw * bz + ax * by - ay * bx + az * bw), f);
        r[3] = clamp32(round_q16(aw * bw - ax * bx - ay * by - az * bz), f);
      end
      qalu_pkg::OP_SCALE: begin
        r[0] = clamp32(round_q16(ax * bx), f);
        r[1] = clamp32(round_q16(ay * bx), f);
        r[2] = clamp32(round_q16(az * bx), f);
        r[3] = clamp32(round_q16(aw * bx), f);
      end
      qalu_pkg::OP_DOT: begin
        r[0] = clamp32(round_q16(ax * bx + ay * by + az * bz + aw * bw), f);
      end
      qalu_pkg::OP_NORM: begin
        s = round_q16(ax * ax + ay * ay + az * az + aw * aw);
        if (s <= wide_t'(eps)) begin
          r[3] = wide_t'(qalu_pkg::Q_ONE);
        end else begin
          quo = (64'd1 << 48) / longint'(s);
          inv = wide_t'(int_sqrt(quo));
          r[0] = clamp32(round_q16(ax * inv), f);
          r[1] = clamp32(round_q16(ay * inv), f);
          r[2] = clamp32(round_q16(az * inv), f);
          r[3] = clamp32(round_q16(aw * inv), f);
        end
      end
      qalu_pkg::OP_ROT, qalu_pkg::OP_UNROT: begin
        sg = (op == qalu_pkg::OP_ROT) ? 80'sd1 : -80'sd1;
        u[0] = sg * ax;
        u[1] = sg * ay;
        u[2] = sg * az;
        v[0] = bx;
        v[1] = by;
        v[2] = bz;
        c[0] = clamp32(80'sd2 * round_q16(u[1] * v[2] - u[2] * v[1]), f);
        c[1] = clamp32(80'sd2 * round_q16(u[2] * v[0] - u[0] * v[2]), f);
        c[2] = clamp32(80'sd2 * round_q16(u[0] * v[1] - u[1] * v[0]), f);
        for (int i = 0; i < 3; i++) t[i] = clamp32(v[i] + round_q16(-sg * aw * c[i]), f);
        r[0] = clamp32(t[0] + round_q16(u[1] * c[2] - u[2] * c[1]), f);
        r[1] = clamp32(t[1] + round_q16(u[2] * c[0] - u[0] * c[2]), f);
        r[2] = clamp32(t[2] + round_q16(u[0] * c[1] - u[1] * c[0]), f);
      end
      default: ;
    endcase
    res.x = r[0][31:0];
    res.y = r[1][31:0];
    res.z = r[2][31:0];
    res.w = r[3][31:0];
    res.sat = f;
    return res;
  endfunction

  task automatic report(string fld, logic [31:0] e, logic [31:0] a);
    $display("%0t mismatch %s: expected %h actual %h", $time, fld, e, a);
    fail_count++;
  endtask

  always @(posedge clk) begin
    quat_res_t exp_r;
    if (!rst_n) begin
      eps_copy <= 31'd1;
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) eps_copy <= cfg_eps_sq;
      if (start && !busy) begin
        awaited_results.push_back(quat_expected_result(in_req_type,
          in_a_x, in_a_y, in_a_z, in_a_w, in_b_x, in_b_y, in_b_z, in_b_w, eps_copy));
      end
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual %h %h %h %h %b",
                   $time, out_r_x, out_r_y, out_r_z, out_r_w, out_saturated);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_r_x !== exp_r.x) report("r_x", exp_r.x, out_r_x);
          if (out_r_y !== exp_r.y) report("r_y", exp_r.y, out_r_y);
          if (out_r_z !== exp_r.z) report("r_z", exp_r.z, out_r_z);
          if (out_r_w !== exp_r.w) report("r_w", exp_r.w, out_r_w);
          if (out_saturated !== exp_r.sat) report("saturated", 32'(exp_r.sat),
                                                  32'(out_saturated));
        end
      end
    end
    in_flight = awaited_results.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the quaternion ALU bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_a_w;
  logic signed [31:0] in_b_x, in_b_y, in_b_z, in_b_w;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [30:0]        cfg_eps_sq;
  logic               out_valid;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic               out_saturated;
  int                 fail_count;
  int                 in_flight;
  int                 burst_left;

  quaternion_alu_core dut (.*);
  quat_result_checker chk (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  task automatic issue(logic [2:0] op, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                       logic [31:0] aw, logic [31:0] bx, logic [31:0] by,
                       logic [31:0] bz, logic [31:0] bw);
    logic taken;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_req_type <= op;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az; in_a_w <= aw;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz; in_b_w <= bw;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (in_flight != 0) @(posedge clk);
    repeat (qalu_pkg::LAT / 8) @(posedge clk);
  endtask

  task automatic write_eps(logic [30:0] val);
    logic taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_eps_sq <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      2: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      3: begin
        case ($urandom_range(0, 4))
          0: return MAX_POS;
          1: return MAX_NEG;
          2: return 32'h0;
          3: return qalu_pkg::Q_ONE;
          default: return -qalu_pkg::Q_ONE;
        endcase
      end
      4: return 32'($signed($urandom_range(0, 32'h1ff)) - 32'sh100);
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
    endcase
  endfunction

  task automatic random_items(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      issue(op, pick_value(), pick_value(), pick_value(), pick_value(),
            pick_value(), pick_value(), pick_value(), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_eps_sq = '0;
    in_req_type = '0;
    {in_a_x, in_a_y, in_a_z, in_a_w} = '0;
    {in_b_x, in_b_y, in_b_z, in_b_w} = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(qalu_pkg::OP_MUL, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG,
          MAX_NEG, MAX_POS, MAX_NEG, MAX_POS);
    issue(qalu_pkg::OP_MUL, qalu_pkg::Q_ONE, 0, 0, qalu_pkg::Q_ONE,
          0, qalu_pkg::Q_ONE, 0, qalu_pkg::Q_ONE);
    issue(qalu_pkg::OP_MUL, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG,
          MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
    issue(qalu_pkg::OP_SCALE, MAX_POS, MAX_NEG, 1, -1, MAX_NEG, 5, 6, 7);
    issue(qalu_pkg::OP_SCALE, 32'h8000, -32'h8000, 32'h18000, 0, 1, 0, 0, 0);
    issue(qalu_pkg::OP_DOT, MAX_POS, MAX_POS, MAX_POS, MAX_POS,
          MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    issue(qalu_pkg::OP_DOT, qalu_pkg::Q_ONE, -qalu_pkg::Q_ONE, 32'h20000, 3,
          32'h8000, 7, -9, 32'h10001);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 0, 1, 2, 3, 4);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 32'd256, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 32'd257, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 32'd363, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, qalu_pkg::Q_ONE, qalu_pkg::Q_ONE, qalu_pkg::Q_ONE,
          qalu_pkg::Q_ONE, 0, 0, 0, 0);
    issue(qalu_pkg::OP_ROT, 0, 0, 32'hb505, 32'hb505, qalu_pkg::Q_ONE, 0, 0, 0);
    issue(qalu_pkg::OP_ROT, MAX_NEG, MAX_POS, MAX_NEG, MAX_NEG,
          MAX_POS, MAX_NEG, MAX_POS, 0);
    issue(qalu_pkg::OP_UNROT, 0, 0, 32'hb505, 32'hb505, qalu_pkg::Q_ONE, 0, 0, 0);
    issue(qalu_pkg::OP_UNROT, MAX_POS, MAX_NEG, MAX_POS, MAX_POS,
          MAX_NEG, MAX_POS, MAX_NEG, MAX_POS);
    issue(OP_SPARE6, MAX_POS, 1, 2, 3, 4, 5, 6, MAX_NEG);
    issue(OP_SPARE7, MAX_NEG, MAX_POS, 1, 1, 1, 1, 1, 1);
    random_items(200);

    write_eps(31'd0);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, 0, 0, 0, 32'd128, 0, 0, 0, 0);
    random_items(200);

    write_eps(31'h7fff_ffff);
    issue(qalu_pkg::OP_NORM, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0);
    issue(qalu_pkg::OP_NORM, 0, 0, 32'h00b5_0000, 32'h00b5_0000, 0, 0, 0, 0);
    random_items(150);

    write_eps(31'($urandom_range(0, 32'h000f_ffff)));
    random_items(250);

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
